// ===== sv/fra_pkg.sv =====
`timescale 1ns / 1ps

package fra_pkg;

  // Sizing of the store
  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int INDEX_BITS = ADDR_BITS + 1;

  // Stream packing
  localparam int IN_DATA_BITS  = ((2 * INDEX_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register index, decoded from paddr[2]
  localparam logic REG_ACTIVE_COUNT = 1'b0;

  // Item kinds carried on the input tuser
  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE_LEAF,
    ST_NODE_FOLD,
    ST_Q_LEAF,
    ST_Q_STEP,
    ST_Q_CHECK,
    ST_OUT
  } state_t;

  // Isolate the lowest set bit of a tree index
  function automatic logic [INDEX_BITS-1:0] low_bit(input logic [INDEX_BITS-1:0] x);
    return x & (~x + 1'b1);
  endfunction

endpackage

// ===== sv/fra_apb.sv =====
`timescale 1ns / 1ps

module fra_apb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fra_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [fra_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [fra_pkg::PDATA_BITS-1:0]    prdata,
  output logic                              pready,
  output logic [fra_pkg::INDEX_BITS-1:0]    active_count
);

  logic                           wr_en;
  logic [fra_pkg::INDEX_BITS-1:0] wr_value;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite &&
                  (paddr[fra_pkg::PADDR_BITS-1] == fra_pkg::REG_ACTIVE_COUNT);

  // Clamp the written count into 1..CAPACITY
  always_comb begin
    if (pwdata == '0) begin
      wr_value = fra_pkg::INDEX_BITS'(1);
    end else if (pwdata > fra_pkg::PDATA_BITS'(fra_pkg::CAPACITY)) begin
      wr_value = fra_pkg::INDEX_BITS'(fra_pkg::CAPACITY);
    end else begin
      wr_value = pwdata[fra_pkg::INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= fra_pkg::INDEX_BITS'(fra_pkg::CAPACITY);
    end else if (wr_en) begin
      active_count <= wr_value;
    end
  end

  // Read back the count; other addresses read as zero
  always_comb begin
    if (paddr[fra_pkg::PADDR_BITS-1] == fra_pkg::REG_ACTIVE_COUNT) begin
      prdata = fra_pkg::PDATA_BITS'(active_count);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== sv/fenwick_range_max.sv =====
`timescale 1ns / 1ps

// Range-maximum store on a binary indexed tree of CAPACITY 16-bit values at
// positions 1..CAPACITY. Items arrive on the s_ stream: tuser 0 writes
// new_value at first_index and returns nothing; tuser 1 returns the maximum
// over first_index..last_index on the m_ stream, with m_tuser set and data 0
// when the bounds are bad. After reset a clearing pass zeroes every entry of
// both memories before the first item is taken; configuration writes are
// taken throughout. One item is worked at a time by a sequencer around a
// single max compare, with one read of the leaf or node memory per fold. An
// update writes its leaf when accepted, then rebuilds each covering node from
// its own leaf and its child nodes. A query folds leaves and whole nodes from
// last_index down to first_index and hands the result to the output register;
// a query with bad bounds goes straight to the output register. The output
// register frees the sequencer once a result is loaded.
module fenwick_range_max (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [10:0] first_index, [21:11] last_index, [37:22] new_value, [39:38] zero
  input  logic [fra_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // [0] cmd
  input  logic                                s_tuser,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] range_max
  output logic [fra_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // [0] range_error
  output logic                                m_tuser,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fra_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [fra_pkg::PDATA_BITS-1:0]      pwdata,
  output logic [fra_pkg::PDATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int IB = fra_pkg::INDEX_BITS;
  localparam int AB = fra_pkg::ADDR_BITS;
  localparam int VB = fra_pkg::VALUE_BITS;

  logic [IB-1:0] active_count;

  fra_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_count (active_count)
  );

  // Memories, position p stored at address p modulo CAPACITY
  logic [VB-1:0] leaf_mem [fra_pkg::CAPACITY];
  logic [VB-1:0] node_mem [fra_pkg::CAPACITY];

  logic          leaf_we, node_we;
  logic [AB-1:0] leaf_waddr, node_waddr, leaf_raddr, node_raddr;
  logic [VB-1:0] leaf_wdata, node_wdata, leaf_rd, node_rd;

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rd <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd <= node_mem[node_raddr];
  end

  // Sequencer registers
  fra_pkg::state_t state, state_next;
  logic [IB-1:0]   pos, pos_next;
  logic [IB-1:0]   lft, lft_next;
  logic [IB-1:0]   step, step_next;
  logic [VB-1:0]   acc, acc_next;
  logic            from_node, from_node_next;
  logic            err_flag, err_flag_next;
  logic [AB-1:0]   clr_addr, clr_addr_next;
  logic [VB-1:0]   upd_value, upd_value_next;
  logic            load_out;

  // Unpack the input transaction
  logic [IB-1:0] in_first, in_last;
  logic [VB-1:0] in_value;
  logic          in_accept, upd_ok, qry_bad;

  assign in_first  = s_tdata[IB-1:0];
  assign in_last   = s_tdata[2*IB-1:IB];
  assign in_value  = s_tdata[2*IB+VB-1:2*IB];
  assign s_tready  = (state == fra_pkg::ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign upd_ok    = (in_first != '0) && (in_first <= active_count);
  assign qry_bad   = (in_first == '0) || (in_first > in_last) || (in_last > active_count);

  // Shared max unit and index arithmetic
  logic [VB-1:0] operand, acc_max;
  logic [IB-1:0] cur_lb;
  logic [IB:0]   next_node;

  assign operand   = from_node ? node_rd : leaf_rd;
  assign acc_max   = (operand > acc) ? operand : acc;
  assign cur_lb    = fra_pkg::low_bit(pos);
  assign next_node = {1'b0, pos} + {1'b0, cur_lb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fra_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    lft       <= lft_next;
    step      <= step_next;
    acc       <= acc_next;
    from_node <= from_node_next;
    err_flag  <= err_flag_next;
    upd_value <= upd_value_next;
  end

  // Next state, datapath and memory controls
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    lft_next       = lft;
    step_next      = step;
    acc_next       = acc;
    from_node_next = from_node;
    err_flag_next  = err_flag;
    clr_addr_next  = clr_addr;
    upd_value_next = upd_value;
    load_out       = 1'b0;
    leaf_we        = 1'b0;
    leaf_waddr     = pos[AB-1:0];
    leaf_wdata     = upd_value;
    leaf_raddr     = pos[AB-1:0];
    node_we        = 1'b0;
    node_waddr     = pos[AB-1:0];
    node_wdata     = acc_max;
    node_raddr     = pos[AB-1:0];

    case (state)
      fra_pkg::ST_CLEAR: begin
        // Zero one entry of each memory per cycle
        leaf_we       = 1'b1;
        leaf_waddr    = clr_addr;
        leaf_wdata    = '0;
        node_we       = 1'b1;
        node_waddr    = clr_addr;
        node_wdata    = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = fra_pkg::ST_IDLE;
        end
      end

      fra_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (s_tuser == fra_pkg::CMD_UPDATE) begin
            // Write the leaf now, then rebuild covering nodes
            if (upd_ok) begin
              leaf_we        = 1'b1;
              leaf_waddr     = in_first[AB-1:0];
              leaf_wdata     = in_value;
              upd_value_next = in_value;
              pos_next       = in_first;
              state_next     = fra_pkg::ST_NODE_LEAF;
            end
          end else if (qry_bad) begin
            acc_next      = '0;
            err_flag_next = 1'b1;
            state_next    = fra_pkg::ST_OUT;
          end else begin
            lft_next      = in_first;
            pos_next      = in_last;
            acc_next      = '0;
            err_flag_next = 1'b0;
            state_next    = fra_pkg::ST_Q_LEAF;
          end
        end
      end

      fra_pkg::ST_NODE_LEAF: begin
        // Start a node rebuild from its own leaf
        leaf_raddr     = pos[AB-1:0];
        acc_next       = '0;
        step_next      = IB'(1);
        from_node_next = 1'b0;
        state_next     = fra_pkg::ST_NODE_FOLD;
      end

      fra_pkg::ST_NODE_FOLD: begin
        acc_next = acc_max;
        if (step < cur_lb) begin
          // Fetch the next child node
          node_raddr     = pos[AB-1:0] - step[AB-1:0];
          step_next      = step << 1;
          from_node_next = 1'b1;
        end else begin
          // Store the rebuilt node and climb to its parent
          node_we    = 1'b1;
          node_waddr = pos[AB-1:0];
          node_wdata = acc_max;
          if (next_node > (IB + 1)'(fra_pkg::CAPACITY)) begin
            state_next = fra_pkg::ST_IDLE;
          end else begin
            pos_next   = next_node[IB-1:0];
            state_next = fra_pkg::ST_NODE_LEAF;
          end
        end
      end

      fra_pkg::ST_Q_LEAF: begin
        leaf_raddr     = pos[AB-1:0];
        from_node_next = 1'b0;
        state_next     = fra_pkg::ST_Q_STEP;
      end

      fra_pkg::ST_Q_STEP: begin
        acc_next = acc_max;
        if (from_node) begin
          state_next = fra_pkg::ST_Q_CHECK;
        end else if (pos == lft) begin
          state_next = fra_pkg::ST_OUT;
        end else begin
          pos_next   = pos - 1'b1;
          state_next = fra_pkg::ST_Q_CHECK;
        end
      end

      fra_pkg::ST_Q_CHECK: begin
        // Take a whole node when it fits inside the range, else a single leaf
        if ((pos - lft) >= cur_lb) begin
          node_raddr     = pos[AB-1:0];
          pos_next       = pos - cur_lb;
          from_node_next = 1'b1;
        end else begin
          leaf_raddr     = pos[AB-1:0];
          from_node_next = 1'b0;
        end
        state_next = fra_pkg::ST_Q_STEP;
      end

      fra_pkg::ST_OUT: begin
        // Hold until the output register is free
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = fra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fra_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= fra_pkg::OUT_DATA_BITS'(acc);
      m_tuser <= err_flag;
    end
  end

endmodule

// ===== sv/fra_check.sv =====
`timescale 1ns / 1ps

module fra_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [fra_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [fra_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  input  logic                                m_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fra_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [fra_pkg::PDATA_BITS-1:0]      pwdata,
  input  logic [fra_pkg::PDATA_BITS-1:0]      prdata,
  input  logic                                pready
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Flag an error result with a zero maximum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result carries a nonzero maximum");

  // Drop ready after taking a query
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == fra_pkg::CMD_QUERY) |=> !s_tready)
    else $error("ready right after a query");

  // Hold off items and results while the memories clear
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("busy state not entered after reset");

  // Keep the readback count within 1..CAPACITY
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && (paddr[fra_pkg::PADDR_BITS-1] == fra_pkg::REG_ACTIVE_COUNT) |->
      (prdata != '0) && (prdata <= fra_pkg::PDATA_BITS'(fra_pkg::CAPACITY)))
    else $error("active count out of range");

endmodule

bind fenwick_range_max fra_check u_fra_check (.*);
